@@ design/medt_pkg.sv @@
// medt_pkg: shared constants, codes and types for the edge dedup table
// no dependencies; imported by medt_ctrl, medt_dpath and the top level
package medt_pkg;

   // fixed field widths of the request and response words
   localparam int VERTEX_W   = 10;
   localparam int REF_W      = 8;
   localparam int TRI_W      = 11;
   localparam int EDGE_IDX_W = 12;
   localparam int STATUS_W   = 2;

   // default table sizes
   localparam int DEF_MAX_VERTICES = 1024;
   localparam int DEF_MAX_EDGES    = 4096;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_CREATED    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SLOTS_FULL = 2'd3;

   // one stored edge
   typedef struct packed {
      logic [VERTEX_W-1:0] low;
      logic [VERTEX_W-1:0] high;
      logic [REF_W-1:0]    tag;
      logic                t1_valid;
      logic [TRI_W-1:0]    t1;
      logic                t2_valid;
      logic [TRI_W-1:0]    t2;
   } edge_entry_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic capture;
      logic calc_quot;
      logic read_head;
      logic follow_head;
      logic follow_link;
      logic attach;
      logic create;
      logic load_out;
   } medt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic head_ok;
      logic link_ok;
      logic match;
      logic clear_last;
      logic out_free;
   } medt_status_type;

endpackage

@@ design/medt_ctrl.sv @@
// medt_ctrl: sequencer for the edge dedup table (clear pass, chain walk, result)
// depends on medt_pkg for the command and status structs
module medt_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  medt_pkg::medt_status_type status,
   output medt_pkg::medt_cmd_type    cmd
);
   import medt_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_QUOT   = 3'd2;
   localparam logic [2:0] S_RDHEAD = 3'd3;
   localparam logic [2:0] S_HEAD   = 3'd4;
   localparam logic [2:0] S_CMP    = 3'd5;
   localparam logic [2:0] S_CREATE = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_QUOT;
            end
         end
         S_QUOT: begin
            cmd.calc_quot = 1'b1;
            state_in      = S_RDHEAD;
         end
         S_RDHEAD: begin
            cmd.read_head = 1'b1;
            state_in      = S_HEAD;
         end
         S_HEAD: begin
            if (status.head_ok) begin
               cmd.follow_head = 1'b1;
               state_in        = S_CMP;
            end else begin
               state_in = S_CREATE;
            end
         end
         S_CMP: begin
            priority if (status.match) begin
               cmd.attach = 1'b1;
               state_in   = S_DONE;
            end else if (status.link_ok) begin
               cmd.follow_link = 1'b1;
            end else begin
               state_in = S_CREATE;
            end
         end
         S_CREATE: begin
            cmd.create = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/medt_dpath.sv @@
// medt_dpath: head table, link table, edge store, edge count and response register
// depends on medt_pkg; driven by medt_ctrl through medt_cmd_type
module medt_dpath #(
   parameter int MAX_VERTICES = medt_pkg::DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = medt_pkg::DEF_MAX_EDGES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  medt_pkg::medt_cmd_type            cmd,
   output medt_pkg::medt_status_type         status,
   input  logic [medt_pkg::VERTEX_W-1:0]     req_first_vertex,
   input  logic [medt_pkg::VERTEX_W-1:0]     req_second_vertex,
   input  logic [medt_pkg::REF_W-1:0]        req_edge_ref,
   input  logic                              req_has_triangle,
   input  logic [medt_pkg::TRI_W-1:0]        req_triangle_index,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [medt_pkg::EDGE_IDX_W-1:0]   rsp_edge_index,
   output logic [medt_pkg::STATUS_W-1:0]     rsp_status,
   output logic [medt_pkg::VERTEX_W-1:0]     rsp_low_vertex,
   output logic [medt_pkg::VERTEX_W-1:0]     rsp_high_vertex
);
   import medt_pkg::*;

   localparam int HeadAw    = $clog2(MAX_VERTICES);
   localparam int EdgeAw    = $clog2(MAX_EDGES);
   localparam int CountW    = $clog2(MAX_EDGES + 1);
   localparam int QuotShift = 2 * VERTEX_W;
   localparam int RecipW    = QuotShift + 1;
   localparam int ProdW     = VERTEX_W + RecipW;
   localparam logic [RecipW-1:0] Recip =
      RecipW'(((1 << QuotShift) + MAX_VERTICES - 1) / MAX_VERTICES);

   typedef struct packed {
      logic              valid;
      logic [EdgeAw-1:0] idx;
   } ptr_type;

   // memories
   ptr_type        heads_mem [MAX_VERTICES];
   ptr_type        links_mem [MAX_EDGES];
   edge_entry_type store_mem [MAX_EDGES];

   // captured request
   logic [VERTEX_W-1:0] lo_ff, hi_ff, lo_in, hi_in;
   logic [REF_W-1:0]    ref_ff;
   logic                has_tri_ff;
   logic [TRI_W-1:0]    tri_ff;

   // bucket select
   logic [VERTEX_W-1:0] quot_ff, quot_in;
   logic [ProdW-1:0]    quot_prod;
   logic [31:0]         quot_times_m;
   logic [VERTEX_W-1:0] rem_val;
   logic [HeadAw-1:0]   bucket_ff, bucket_in;

   // walk state
   ptr_type             head_q_ff, link_q_ff;
   edge_entry_type      entry_q_ff;
   logic [EdgeAw-1:0]   ptr_ff, follow_addr;
   logic [CountW-1:0]   count_ff, count_in;
   logic [HeadAw-1:0]   clr_ff, clr_in;
   logic                table_full;

   // entry updates
   edge_entry_type      entry_upd, entry_new;
   logic [STATUS_W-1:0] att_status;

   // result and output
   logic [EDGE_IDX_W-1:0] res_idx_ff;
   logic [STATUS_W-1:0]   res_status_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [EDGE_IDX_W-1:0] rsp_idx_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [VERTEX_W-1:0]   rsp_lo_ff, rsp_hi_ff;

   // vertex ordering on the incoming word
   always_comb begin
      if (req_first_vertex < req_second_vertex) begin
         lo_in = req_first_vertex;
         hi_in = req_second_vertex;
      end else begin
         lo_in = req_second_vertex;
         hi_in = req_first_vertex;
      end
   end

   // low vertex modulo head depth by reciprocal multiply, exact for 10-bit values
   assign quot_prod    = ProdW'(lo_ff) * ProdW'(Recip);
   assign quot_in      = quot_prod[QuotShift +: VERTEX_W];
   assign quot_times_m = 32'(quot_ff) * 32'(MAX_VERTICES);
   assign rem_val      = lo_ff - quot_times_m[VERTEX_W-1:0];
   assign bucket_in    = HeadAw'(rem_val);

   assign table_full  = (count_ff == CountW'(MAX_EDGES));
   assign follow_addr = cmd.follow_head ? head_q_ff.idx : link_q_ff.idx;

   // triangle slot fill on a match
   always_comb begin
      entry_upd  = entry_q_ff;
      att_status = ST_FOUND;
      if (has_tri_ff) begin
         priority if (!entry_q_ff.t1_valid) begin
            entry_upd.t1_valid = 1'b1;
            entry_upd.t1       = tri_ff;
         end else if (!entry_q_ff.t2_valid) begin
            entry_upd.t2_valid = 1'b1;
            entry_upd.t2       = tri_ff;
         end else begin
            att_status = ST_SLOTS_FULL;
         end
      end
   end

   always_comb begin
      entry_new.low      = lo_ff;
      entry_new.high     = hi_ff;
      entry_new.tag      = ref_ff;
      entry_new.t1_valid = has_tri_ff;
      entry_new.t1       = has_tri_ff ? tri_ff : '0;
      entry_new.t2_valid = 1'b0;
      entry_new.t2       = '0;
   end

   assign status.head_ok    = head_q_ff.valid && (CountW'(head_q_ff.idx) < count_ff);
   assign status.link_ok    = link_q_ff.valid && (CountW'(link_q_ff.idx) < count_ff);
   assign status.match      = (entry_q_ff.low == lo_ff) && (entry_q_ff.high == hi_ff);
   assign status.clear_last = (clr_ff == HeadAw'(MAX_VERTICES - 1));
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   // head table: clear pass and link-in, one read port
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         heads_mem[clr_ff] <= '0;
      end else if (cmd.create && !table_full) begin
         heads_mem[bucket_ff] <= '{valid: 1'b1, idx: count_ff[EdgeAw-1:0]};
      end
      if (cmd.read_head) begin
         head_q_ff <= heads_mem[bucket_in];
      end
   end

   // link table and edge store share address sources
   always_ff @(posedge clock) begin
      if (cmd.create && !table_full) begin
         links_mem[count_ff[EdgeAw-1:0]] <= head_q_ff;
      end
      if (cmd.follow_head || cmd.follow_link) begin
         link_q_ff <= links_mem[follow_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.create && !table_full) begin
         store_mem[count_ff[EdgeAw-1:0]] <= entry_new;
      end else if (cmd.attach) begin
         store_mem[ptr_ff] <= entry_upd;
      end
      if (cmd.follow_head || cmd.follow_link) begin
         entry_q_ff <= store_mem[follow_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lo_ff      <= lo_in;
         hi_ff      <= hi_in;
         ref_ff     <= req_edge_ref;
         has_tri_ff <= req_has_triangle;
         tri_ff     <= req_triangle_index;
      end
      if (cmd.calc_quot) quot_ff <= quot_in;
      if (cmd.read_head) bucket_ff <= bucket_in;
      if (cmd.follow_head || cmd.follow_link) ptr_ff <= follow_addr;
      if (cmd.attach) begin
         res_idx_ff    <= EDGE_IDX_W'(ptr_ff);
         res_status_ff <= att_status;
      end else if (cmd.create) begin
         res_idx_ff    <= table_full ? '0 : EDGE_IDX_W'(count_ff);
         res_status_ff <= table_full ? ST_TABLE_FULL : ST_CREATED;
      end
      if (cmd.load_out) begin
         rsp_idx_ff    <= res_idx_ff;
         rsp_status_ff <= res_status_ff;
         rsp_lo_ff     <= lo_ff;
         rsp_hi_ff     <= hi_ff;
      end
   end

   // control registers
   always_comb begin
      count_in = count_ff;
      if (cmd.create && !table_full) count_in = count_ff + CountW'(1);
      clr_in = clr_ff;
      if (cmd.clear) clr_in = status.clear_last ? '0 : clr_ff + HeadAw'(1);
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (!rsp_stall)       rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_edge_index  = rsp_idx_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_low_vertex  = rsp_lo_ff;
   assign rsp_high_vertex = rsp_hi_ff;

endmodule

@@ design/mesh_edge_dedup_table_unit.sv @@
// mesh_edge_dedup_table_unit: top level of the mesh edge dedup table
// depends on medt_pkg, medt_ctrl and medt_dpath
//
//  channel | direction | handshake          | word
//  req_    | in        | req_valid/req_stall | first, second vertex, ref tag, triangle
//  rsp_    | out       | rsp_valid/rsp_stall | edge index, status, low and high vertex
//
// flow: one word at a time; quotient, head read, head check, one compare per entry
//   walked in the low vertex chain, create or attach, then done; the chain walk
//   reads one store entry per cycle from the edge store port
// reset: synchronous; a clearing pass then empties the head table, all MAX_VERTICES
//   entries (1024 by default), with req_stall high throughout
// stalls: the response sits in an output register, so a new request is taken
//   while rsp_stall holds the last word; only the next result waits for it
module mesh_edge_dedup_table_unit #(
   parameter int MAX_VERTICES = medt_pkg::DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = medt_pkg::DEF_MAX_EDGES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [medt_pkg::VERTEX_W-1:0]   req_first_vertex,
   input  logic [medt_pkg::VERTEX_W-1:0]   req_second_vertex,
   input  logic [medt_pkg::REF_W-1:0]      req_edge_ref,
   input  logic                            req_has_triangle,
   input  logic [medt_pkg::TRI_W-1:0]      req_triangle_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [medt_pkg::EDGE_IDX_W-1:0] rsp_edge_index,
   output logic [medt_pkg::STATUS_W-1:0]   rsp_status,
   output logic [medt_pkg::VERTEX_W-1:0]   rsp_low_vertex,
   output logic [medt_pkg::VERTEX_W-1:0]   rsp_high_vertex
);
   import medt_pkg::*;

   medt_cmd_type    cmd;
   medt_status_type status;

   // sequencer: clear pass, head lookup, chain walk, create or attach
   medt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // tables, edge count and response register
   medt_dpath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_first_vertex   (req_first_vertex),
      .req_second_vertex  (req_second_vertex),
      .req_edge_ref       (req_edge_ref),
      .req_has_triangle   (req_has_triangle),
      .req_triangle_index (req_triangle_index),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_edge_index     (rsp_edge_index),
      .rsp_status         (rsp_status),
      .rsp_low_vertex     (rsp_low_vertex),
      .rsp_high_vertex    (rsp_high_vertex)
   );

   // one word in flight: an accept closes the request side next cycle
   a_accept_then_stall: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a word is in flight");

   // no requests during the head table clearing pass
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> req_stall)
      else $error("request side open during clearing pass");

   // the response register is only loaded when it is free
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || !rsp_stall))
      else $error("response overwritten while stalled");

   // a dropped edge reports index zero
   a_full_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_TABLE_FULL)) |-> (rsp_edge_index == '0))
      else $error("table full response with nonzero index");

endmodule

@@ verif/medt_edge_checker.sv @@
`timescale 1ns / 100ps
// medt_edge_checker: watches the request and response channels of the edge dedup table,
// keeps its own copy of the chain heads, links and edge store, and compares every response
// depends on medt_pkg for field widths, status codes and the stored edge layout
module medt_edge_checker #(
   parameter int NUM_VERTICES = medt_pkg::DEF_MAX_VERTICES,
   parameter int NUM_EDGES    = medt_pkg::DEF_MAX_EDGES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [medt_pkg::VERTEX_W-1:0]   req_first_vertex,
   input  logic [medt_pkg::VERTEX_W-1:0]   req_second_vertex,
   input  logic [medt_pkg::REF_W-1:0]      req_edge_ref,
   input  logic                            req_has_triangle,
   input  logic [medt_pkg::TRI_W-1:0]      req_triangle_index,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [medt_pkg::EDGE_IDX_W-1:0] rsp_edge_index,
   input  logic [medt_pkg::STATUS_W-1:0]   rsp_status,
   input  logic [medt_pkg::VERTEX_W-1:0]   rsp_low_vertex,
   input  logic [medt_pkg::VERTEX_W-1:0]   rsp_high_vertex,
   output int                              mismatches,
   output int                              awaiting
);
   import medt_pkg::*;

   typedef struct {
      logic [EDGE_IDX_W-1:0] entry_index;
      logic [STATUS_W-1:0]   status;
      logic [VERTEX_W-1:0]   low;
      logic [VERTEX_W-1:0]   high;
   } edge_answer_type;

   bit             head_valid [NUM_VERTICES];
   int unsigned    head_entry [NUM_VERTICES];
   bit             link_valid [NUM_EDGES];
   int unsigned    link_entry [NUM_EDGES];
   edge_entry_type edge_table [NUM_EDGES];
   int unsigned    edge_total;

   edge_answer_type awaited_answers [$];

   task automatic report_mismatch(input string msg);
      if (mismatches < 100)
         $display("[%0t] medt_edge_checker: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [EDGE_IDX_W-1:0] got,
                              input logic [EDGE_IDX_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // walk the low vertex chain; attach on a match, else append, link at head unless full
   function automatic edge_answer_type resolve_edge(input logic [VERTEX_W-1:0] a,
                                                    input logic [VERTEX_W-1:0] b,
                                                    input logic [REF_W-1:0] tag,
                                                    input logic has_tri,
                                                    input logic [TRI_W-1:0] triangle);
      edge_answer_type     ans;
      logic [VERTEX_W-1:0] lo;
      logic [VERTEX_W-1:0] hi;
      int unsigned         head;
      int unsigned         cur;
      int unsigned         steps;
      bit                  cur_ok;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      head = lo % NUM_VERTICES;
      cur_ok = head_valid[head];
      cur = head_entry[head];
      steps = 0;
      ans.low = lo;
      ans.high = hi;
      while (cur_ok && cur < edge_total && steps < edge_total) begin
         if (edge_table[cur].low == lo && edge_table[cur].high == hi) begin
            ans.entry_index = cur[EDGE_IDX_W-1:0];
            ans.status = ST_FOUND;
            if (has_tri) begin
               if (!edge_table[cur].t1_valid) begin
                  edge_table[cur].t1_valid = 1'b1;
                  edge_table[cur].t1 = triangle;
               end else if (!edge_table[cur].t2_valid) begin
                  edge_table[cur].t2_valid = 1'b1;
                  edge_table[cur].t2 = triangle;
               end else begin
                  ans.status = ST_SLOTS_FULL;
               end
            end
            return ans;
         end
         cur_ok = link_valid[cur];
         cur = link_entry[cur];
         steps++;
      end
      if (edge_total >= NUM_EDGES) begin
         ans.entry_index = '0;
         ans.status = ST_TABLE_FULL;
         return ans;
      end
      edge_table[edge_total].low = lo;
      edge_table[edge_total].high = hi;
      edge_table[edge_total].tag = tag;
      edge_table[edge_total].t1_valid = has_tri;
      edge_table[edge_total].t1 = has_tri ? triangle : '0;
      edge_table[edge_total].t2_valid = 1'b0;
      edge_table[edge_total].t2 = '0;
      link_valid[edge_total] = head_valid[head];
      link_entry[edge_total] = head_entry[head];
      head_valid[head] = 1'b1;
      head_entry[head] = edge_total;
      ans.entry_index = edge_total[EDGE_IDX_W-1:0];
      ans.status = ST_CREATED;
      edge_total++;
      return ans;
   endfunction

   always @(posedge clock) begin
      edge_answer_type want;
      if (reset) begin
         awaited_answers.delete();
         foreach (head_valid[i]) head_valid[i] = 1'b0;
         edge_total = 0;
      end else begin
         // compare before predicting so a stray response cannot meet a fresh expectation
         if (rsp_valid && !rsp_stall) begin
            if (awaited_answers.size() == 0) begin
               report_mismatch($sformatf("unexpected response index %0d status %0d",
                                         rsp_edge_index, rsp_status));
            end else begin
               want = awaited_answers.pop_front();
               check_field("edge_index", rsp_edge_index, want.entry_index);
               check_field("status", EDGE_IDX_W'(rsp_status), EDGE_IDX_W'(want.status));
               check_field("low_vertex", EDGE_IDX_W'(rsp_low_vertex), EDGE_IDX_W'(want.low));
               check_field("high_vertex", EDGE_IDX_W'(rsp_high_vertex),
                           EDGE_IDX_W'(want.high));
            end
         end
         if (req_valid && !req_stall)
            awaited_answers.push_back(resolve_edge(req_first_vertex, req_second_vertex,
                                                   req_edge_ref, req_has_triangle,
                                                   req_triangle_index));
      end
      awaiting <= awaited_answers.size();
   end

endmodule

@@ verif/mesh_edge_dedup_table_unit_tb.sv @@
`timescale 1ns / 100ps
// mesh_edge_dedup_table_unit_tb: drives edge words into the dedup table and gives the verdict
// depends on medt_pkg, the mesh_edge_dedup_table_unit design and medt_edge_checker
module mesh_edge_dedup_table_unit_tb;
   import medt_pkg::*;

   // table depth of the default build; the fill phase runs it up to this many entries
   localparam int TABLE_DEPTH = DEF_MAX_EDGES;
   // worst case is several times the slowest expected run (about 5300 words, chain walks,
   // long gaps and stalls on both sides, the long hold and the head clearing pass)
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int RANDOM_WORDS = 1000;
   localparam int HOLD_CYCLES = 400;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [VERTEX_W-1:0]   req_first_vertex;
   logic [VERTEX_W-1:0]   req_second_vertex;
   logic [REF_W-1:0]      req_edge_ref;
   logic                  req_has_triangle;
   logic [TRI_W-1:0]      req_triangle_index;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [EDGE_IDX_W-1:0] rsp_edge_index;
   logic [STATUS_W-1:0]   rsp_status;
   logic [VERTEX_W-1:0]   rsp_low_vertex;
   logic [VERTEX_W-1:0]   rsp_high_vertex;

   int mismatches;
   int awaiting;
   int cycle_count;

   // steady: no idling on either side for a stretch; hold_armed: ask for the long stall
   bit steady;
   bit hold_armed;

   // vertex pairs that got (or will get) a table entry, kept to replay known edges
   bit                  pair_known [int];
   logic [VERTEX_W-1:0] pool_lo [$];
   logic [VERTEX_W-1:0] pool_hi [$];

   mesh_edge_dedup_table_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_vertex   (req_first_vertex),
      .req_second_vertex  (req_second_vertex),
      .req_edge_ref       (req_edge_ref),
      .req_has_triangle   (req_has_triangle),
      .req_triangle_index (req_triangle_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_edge_index     (rsp_edge_index),
      .rsp_status         (rsp_status),
      .rsp_low_vertex     (rsp_low_vertex),
      .rsp_high_vertex    (rsp_high_vertex)
   );

   medt_edge_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_vertex   (req_first_vertex),
      .req_second_vertex  (req_second_vertex),
      .req_edge_ref       (req_edge_ref),
      .req_has_triangle   (req_has_triangle),
      .req_triangle_index (req_triangle_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_edge_index     (rsp_edge_index),
      .rsp_status         (rsp_status),
      .rsp_low_vertex     (rsp_low_vertex),
      .rsp_high_vertex    (rsp_high_vertex),
      .mismatches         (mismatches),
      .awaiting           (awaiting)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("mesh_edge_dedup_table_unit_tb: errors");
         $finish;
      end
   end

   // idle length: mostly none or short, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (steady || roll < 55)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one edge word and wait for the handshake; valid stays high into the next word
   // unless a gap is picked, so valid gets at most one update per clock edge
   task automatic send_edge(input logic [VERTEX_W-1:0] a, input logic [VERTEX_W-1:0] b,
                            input logic [REF_W-1:0] tag, input logic has_tri,
                            input logic [TRI_W-1:0] triangle);
      int unsigned         gap;
      int                  key;
      logic [VERTEX_W-1:0] lo;
      logic [VERTEX_W-1:0] hi;
      gap = pick_gap();
      if (gap > 0) begin
         // junk on the payload while valid is low
         req_valid <= 1'b0;
         req_first_vertex <= VERTEX_W'($urandom);
         req_second_vertex <= VERTEX_W'($urandom);
         req_edge_ref <= REF_W'($urandom);
         req_has_triangle <= 1'($urandom);
         req_triangle_index <= TRI_W'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_first_vertex <= a;
      req_second_vertex <= b;
      req_edge_ref <= tag;
      req_has_triangle <= has_tri;
      req_triangle_index <= triangle;
      do @(posedge clock); while (req_stall);
      // remember pairs that get an entry; once the table is full new pairs are dropped
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      key = int'(lo) * 1024 + int'(hi);
      if (!pair_known.exists(key) && pair_known.num() < TABLE_DEPTH) begin
         pair_known[key] = 1'b1;
         pool_lo.push_back(lo);
         pool_hi.push_back(hi);
      end
   endtask

   // a vertex pair that has no table entry yet
   task automatic pick_fresh_pair(output logic [VERTEX_W-1:0] lo,
                                  output logic [VERTEX_W-1:0] hi);
      do begin
         lo = VERTEX_W'($urandom_range(1023));
         hi = VERTEX_W'($urandom_range(1023));
         if (hi < lo) {lo, hi} = {hi, lo};
      end while (pair_known.exists(int'(lo) * 1024 + int'(hi)));
   endtask

   // send a pair in either order with random tag and triangle
   task automatic send_pair(input logic [VERTEX_W-1:0] lo, input logic [VERTEX_W-1:0] hi);
      if ($urandom_range(1))
         send_edge(hi, lo, REF_W'($urandom), $urandom_range(99) < 70, TRI_W'($urandom));
      else
         send_edge(lo, hi, REF_W'($urandom), $urandom_range(99) < 70, TRI_W'($urandom));
   endtask

   // receiver: random stall stretches, plus one long hold that backs the block up
   initial begin : rsp_side
      bit          hold_spent;
      int unsigned gap;
      hold_spent = 1'b0;
      forever begin
         if (hold_armed && !hold_spent) begin
            hold_spent = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   initial begin : req_side
      logic [VERTEX_W-1:0] lo;
      logic [VERTEX_W-1:0] hi;
      int unsigned         k;
      int unsigned         roll;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_first_vertex <= '0;
      req_second_vertex <= '0;
      req_edge_ref <= '0;
      req_has_triangle <= 1'b0;
      req_triangle_index <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: degenerate edges, field extremes, swapped order, slot filling
      send_edge(10'd0, 10'd0, 8'h00, 1'b0, 11'h7ff);        // degenerate, no triangle
      send_edge(10'd1023, 10'd1023, 8'hff, 1'b1, 11'h7ff);  // degenerate at the top
      send_edge(10'd1023, 10'd0, 8'h55, 1'b1, 11'h000);     // swapped order, slot one
      send_edge(10'd0, 10'd1023, 8'haa, 1'b1, 11'h555);     // found, second slot
      send_edge(10'd1023, 10'd0, 8'h33, 1'b1, 11'h2aa);     // both slots taken
      send_edge(10'd0, 10'd1023, 8'hcc, 1'b0, 11'h7ff);     // found, no triangle
      send_edge(10'd0, 10'd0, 8'h0f, 1'b1, 11'd1234);       // found, first slot
      send_edge(10'd0, 10'd0, 8'hf0, 1'b1, 11'd1234);       // repeated triangle kept
      send_edge(10'd0, 10'd0, 8'h01, 1'b1, 11'd7);          // both slots taken
      send_edge(10'd0, 10'd1, 8'h80, 1'b0, 11'd0);          // third entry on chain zero
      send_edge(10'd1, 10'd0, 8'h7f, 1'b1, 11'd2047);       // found at the chain head
      send_edge(10'd1023, 10'd0, 8'h02, 1'b0, 11'd3);       // walk past the head entry
      send_edge(10'd5, 10'd3, 8'h12, 1'b1, 11'd100);
      send_edge(10'd3, 10'd5, 8'h34, 1'b1, 11'd101);
      send_edge(10'd512, 10'd511, 8'h56, 1'b0, 11'h400);
      send_edge(10'd511, 10'd512, 8'h78, 1'b1, 11'h3ff);
      send_edge(10'd1022, 10'd1023, 8'h9a, 1'b1, 11'h001);
      send_edge(10'd3, 10'd1022, 8'hbc, 1'b0, 11'h0);

      // random mix: replays of known edges to fill slots, hot low vertices for long
      // chains and wide random pairs; one quiet stretch and one long receiver hold
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 200) hold_armed = 1'b1;
         steady = (n >= 600 && n < 700);
         roll = $urandom_range(99);
         if (roll < 55) begin
            k = $urandom_range(pool_lo.size() - 1);
            lo = pool_lo[k];
            hi = pool_hi[k];
         end else if (roll < 85) begin
            lo = VERTEX_W'($urandom_range(15));
            hi = VERTEX_W'($urandom_range(1023));
         end else begin
            lo = VERTEX_W'($urandom_range(1023));
            hi = VERTEX_W'($urandom_range(1023));
         end
         send_pair(lo, hi);
      end
      steady = 1'b0;

      // fill the table with new edges up to its depth
      while (pair_known.num() < TABLE_DEPTH) begin
         pick_fresh_pair(lo, hi);
         send_pair(lo, hi);
      end

      // table full: new edges are dropped, known ones still match
      for (int n = 0; n < 80; n++) begin
         if ($urandom_range(1)) begin
            k = $urandom_range(pool_lo.size() - 1);
            lo = pool_lo[k];
            hi = pool_hi[k];
         end else begin
            pick_fresh_pair(lo, hi);
         end
         send_pair(lo, hi);
      end
      req_valid <= 1'b0;

      // drain: the awaited count is registered, so the last accept shows up in it the cycle after
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      if (mismatches == 0)
         $display("mesh_edge_dedup_table_unit_tb: clean");
      else
         $display("mesh_edge_dedup_table_unit_tb: errors");
      $finish;
   end

endmodule
